// ===== hw/rtl/operand_stack_with_rotate_unit_macros.svh =====
// Assertion macros for the operand stack RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef OPERAND_STACK_WITH_ROTATE_UNIT_MACROS_SVH
`define OPERAND_STACK_WITH_ROTATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OSR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OSR_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/osr_pkg.sv =====
// Shared types and constants of the operand stack.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package osr_pkg;

  localparam int DEPTH   = 64;
  localparam int WORD_W  = 32;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 7;                    // width of the count fields on the ports
  localparam int CNT_W   = $clog2(DEPTH + 1);    // internal entry count
  localparam int IDX_W   = $clog2(DEPTH);        // cell position
  localparam int CMP_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_DROP   = 3'd4,
    CMD_ROTATE = 3'd5,
    CMD_DUP    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_TOO_MANY = 2'd3
  } stat_t;

  // What every cell of the chain does.
  typedef enum logic [2:0] {
    COP_HOLD       = 3'd0,
    COP_SHIFT_DOWN = 3'd1,
    COP_DUP        = 3'd2,
    COP_SHIFT_UP   = 3'd3,
    COP_ROTATE     = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] rot_n;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/osr_cell.sv =====
// One storage cell of the stack chain; cell 0 holds the top of the stack.
// Depends on osr_pkg.
`timescale 1ns / 1ps

module osr_cell (
  input  logic                              clk,
  input  logic [osr_pkg::IDX_W-1:0]         cell_idx,
  input  osr_pkg::cell_ctl_t                ctl,
  input  logic signed [osr_pkg::WORD_W-1:0] prev_word,  // from the cell above
  input  logic signed [osr_pkg::WORD_W-1:0] next_word,  // from the cell below
  input  logic signed [osr_pkg::WORD_W-1:0] top_word,
  output logic signed [osr_pkg::WORD_W-1:0] word
);
  import osr_pkg::*;

  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] word_nxt;
  logic        [CNT_W-1:0]  pos;

  // Position counted from 1 at the top.
  assign pos = CNT_W'(cell_idx) + CNT_W'(1);

  always_comb begin
    word_nxt = word_r;
    unique case (ctl.op)
      COP_HOLD:       word_nxt = word_r;
      COP_SHIFT_DOWN: word_nxt = prev_word;
      COP_DUP:        word_nxt = (cell_idx == '0) ? word_r : prev_word;
      COP_SHIFT_UP:   word_nxt = next_word;
      COP_ROTATE: begin
        priority if (pos < ctl.rot_n) word_nxt = next_word;
        else if (pos == ctl.rot_n)    word_nxt = top_word;
        else                          word_nxt = word_r;
      end
      default:        word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== hw/rtl/osr_ctrl.sv =====
// Command decoder, entry counter, drop sequencer and result register.
// Depends on osr_pkg and operand_stack_with_rotate_unit_macros.svh.
`timescale 1ns / 1ps
`include "operand_stack_with_rotate_unit_macros.svh"

module osr_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [osr_pkg::CMD_W-1:0]         in_cmd,
  input  logic [osr_pkg::COUNT_W-1:0]       in_count,
  input  logic signed [osr_pkg::WORD_W-1:0] top_word,
  output osr_pkg::cell_ctl_t                cell_ctl,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [osr_pkg::WORD_W-1:0] res_value,
  output osr_pkg::stat_t                    res_status,
  output logic [osr_pkg::COUNT_W-1:0]       res_entries
);
  import osr_pkg::*;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_DROP = 2'b10
  } fsm_t;

  fsm_t                     state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         drop_left_r, drop_left_nxt;
  logic                     out_valid_r;
  logic signed [WORD_W-1:0] res_value_r, res_value_nxt;
  stat_t                    res_status_r, res_status_nxt;
  logic [CNT_W-1:0]         res_entries_r;
  logic                     fire;
  logic [CMP_W-1:0]         n_ext, cnt_ext;
  logic [CNT_W-1:0]         n_cnt;
  logic                     full, empty, n_too_big;

  assign in_ready  = (state_r == FSM_IDLE) && (!out_valid_r || out_ready);
  assign fire      = in_valid && in_ready;
  assign n_ext     = CMP_W'(in_count);
  assign cnt_ext   = CMP_W'(count_r);
  assign n_too_big = n_ext > cnt_ext;
  assign n_cnt     = CNT_W'(n_ext);  // only used once n fits the count
  assign full      = count_r == CNT_W'(DEPTH);
  assign empty     = count_r == '0;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    drop_left_nxt  = drop_left_r;
    cell_ctl.op    = COP_HOLD;
    cell_ctl.rot_n = n_cnt;
    res_value_nxt  = '0;
    res_status_nxt = STAT_OK;
    if (state_r == FSM_DROP) begin
      // advance a multi-entry drop one place per cycle
      cell_ctl.op   = COP_SHIFT_UP;
      drop_left_nxt = drop_left_r - CNT_W'(1);
      if (drop_left_r == CNT_W'(1)) state_nxt = FSM_IDLE;
    end else if (fire) begin
      unique case (cmd_t'(in_cmd))
        CMD_PUSH: begin
          if (full) res_status_nxt = STAT_FULL;
          else begin
            cell_ctl.op = COP_SHIFT_DOWN;
            count_nxt   = count_r + CNT_W'(1);
          end
        end
        CMD_POP: begin
          if (empty) res_status_nxt = STAT_EMPTY;
          else begin
            res_value_nxt = top_word;
            cell_ctl.op   = COP_SHIFT_UP;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        CMD_PEEK: begin
          if (empty) res_status_nxt = STAT_EMPTY;
          else res_value_nxt = top_word;
        end
        CMD_CLEAR: count_nxt = '0;
        CMD_DROP: begin
          if (n_too_big) res_status_nxt = STAT_TOO_MANY;
          else begin
            count_nxt = count_r - n_cnt;
            // dropping everything needs no shifting
            if (n_cnt != '0 && n_cnt != count_r) begin
              cell_ctl.op   = COP_SHIFT_UP;
              drop_left_nxt = n_cnt - CNT_W'(1);
              if (n_cnt != CNT_W'(1)) state_nxt = FSM_DROP;
            end
          end
        end
        CMD_ROTATE: begin
          if (n_too_big) res_status_nxt = STAT_TOO_MANY;
          else if (n_cnt > CNT_W'(1)) cell_ctl.op = COP_ROTATE;
        end
        CMD_DUP: begin
          priority if (empty) res_status_nxt = STAT_EMPTY;
          else if (full) res_status_nxt = STAT_FULL;
          else begin
            cell_ctl.op = COP_DUP;
            count_nxt   = count_r + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      drop_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_left_r <= drop_left_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_value_r   <= res_value_nxt;
      res_status_r  <= res_status_nxt;
      res_entries_r <= count_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign res_value   = res_value_r;
  assign res_status  = res_status_r;
  assign res_entries = COUNT_W'(res_entries_r);

  `OSR_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `OSR_ASSERT_NXT(a_result_follows, fire, out_valid_r, "transfer without a result")
  `OSR_ASSERT_IMP(a_drop_left, state_r == FSM_DROP, drop_left_r != '0, "drop with nothing left")
  `OSR_ASSERT_NXT(a_push_count, fire && cmd_t'(in_cmd) == CMD_PUSH && !full,
                  count_r == $past(count_r) + CNT_W'(1), "push did not bump count")

endmodule

// ===== hw/rtl/operand_stack_with_rotate_unit.sv =====
// Top level of the operand stack: a chain of word cells plus its controller.
// Depends on osr_pkg, osr_cell and osr_ctrl.
`timescale 1ns / 1ps

// Operand stack for an interpreter: a LIFO of DEPTH (64) signed 32-bit words
// built as a chain of cells, cell 0 holding the top. Each transfer on the in_
// side carries one command (push, pop, peek, clear, drop n, rotate n, dup) and
// yields exactly one transfer on the out_ side with the popped or peeked word,
// a status and the entry count after the command. Drop n shifts the chain one
// place per cycle and takes no new command until all n places are shifted;
// every other command, and a drop of 0, 1 or the whole stack, holds off none.
// Results wait in an output register; outside a drop, a new command is taken
// in the same cycle that the result is transferred. Cells are not reset.
module operand_stack_with_rotate_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] push_value, [38:32] count, [39] zero
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] result_value, [38:32] entries_now, [39] is_empty
  output logic [1:0]  out_tuser   // [1:0] status
);
  import osr_pkg::*;

  logic signed [WORD_W-1:0] push_value;
  logic        [COUNT_W-1:0] in_count;
  logic signed [WORD_W-1:0] cell_word [DEPTH];
  logic signed [WORD_W-1:0] res_value;
  stat_t                    res_status;
  logic        [COUNT_W-1:0] res_entries;
  cell_ctl_t                cell_ctl;

  // unpack the command fields
  assign push_value = in_tdata[WORD_W-1:0];
  assign in_count   = in_tdata[WORD_W+COUNT_W-1:WORD_W];

  osr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_count    (in_count),
    .top_word    (cell_word[0]),
    .cell_ctl    (cell_ctl),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .res_value   (res_value),
    .res_status  (res_status),
    .res_entries (res_entries)
  );

  // Chain: each cell sees its two neighbors and the top word. The push word
  // enters above cell 0; the bottom cell sees itself from below.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] prev_w;
    logic signed [WORD_W-1:0] next_w;

    if (g == 0) begin : g_first
      assign prev_w = push_value;
    end else begin : g_mid
      assign prev_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cell_word[g];
    end else begin : g_inner
      assign next_w = cell_word[g+1];
    end

    osr_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .ctl       (cell_ctl),
      .prev_word (prev_w),
      .next_word (next_w),
      .top_word  (cell_word[0]),
      .word      (cell_word[g])
    );
  end

  // pack the result
  assign out_tdata = {(res_entries == '0), res_entries, res_value};
  assign out_tuser = res_status;

endmodule
